// ----- hw/rtl/ptw_pkg.sv -----
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

    // Field widths.
    localparam int ADDR_W     = 52;
    localparam int WORD_W     = 64;
    localparam int VA_W       = 48;
    localparam int IDX_W      = 9;
    localparam int FRAME_W    = 40;
    localparam int WORD_IDX_W = 49;
    localparam int PSIZE_W    = 2;

    // Entry flag bit positions.
    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    // Item kinds.
    localparam logic MODE_WRITE     = 1'b0;
    localparam logic MODE_TRANSLATE = 1'b1;

    // Page size codes.
    localparam logic [PSIZE_W-1:0] PS_4K = 2'd0;
    localparam logic [PSIZE_W-1:0] PS_2M = 2'd1;
    localparam logic [PSIZE_W-1:0] PS_1G = 2'd2;

    // Table levels.
    typedef logic [1:0] lvl_t;
    localparam lvl_t LVL_PML4 = 2'd0;
    localparam lvl_t LVL_PDPT = 2'd1;
    localparam lvl_t LVL_PD   = 2'd2;
    localparam lvl_t LVL_PT   = 2'd3;

    // How a walk ends.
    typedef enum logic [1:0] {
        RES_FAULT = 2'd0,
        RES_GIG   = 2'd1,
        RES_MEG   = 2'd2,
        RES_SMALL = 2'd3
    } res_kind_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic      wr_en;
        logic      clr_step;
        logic      load_va;
        logic      rd_en;
        logic      sel_root;
        lvl_t      level;
        logic      load_result;
        res_kind_t kind;
    } ctl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic wr_ok;
        logic addr_ok;
        logic present;
        logic big_page;
        logic clear_last;
    } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ptw_if.sv -----
// ----------------------------------------------------------------------------
// ptw_cmd_if / ptw_rsp_if
// Valid/ready channels for incoming items and translation results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptw_cmd_if
    import ptw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                mode;
    logic [ADDR_W-1:0]   word_phys_addr;
    logic [WORD_W-1:0]   word_value;
    logic [VA_W-1:0]     virt_addr;

    modport source (output valid, mode, word_phys_addr, word_value, virt_addr,
                    input ready);
    modport sink   (input valid, mode, word_phys_addr, word_value, virt_addr,
                    output ready);
endinterface

interface ptw_rsp_if
    import ptw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   phys_addr;
    logic                translated;
    logic [PSIZE_W-1:0]  page_size;

    modport source (output valid, phys_addr, translated, page_size, input ready);
    modport sink   (input valid, phys_addr, translated, page_size, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/four_level_page_table_walker_unit.sv -----
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit
// Four-level page table walker over an internal table store.
// ----------------------------------------------------------------------------
// After reset the unit zeroes its table store, one word per cycle, through
// all STORE_WORDS words; no item is taken during that pass, though the root
// register may be written. A write item gives no result. A translate item
// reads one table entry per cycle from the store, whose read port is
// registered; the walk ends at once when the root table lies outside the
// store, else at a fault or a leaf entry, and loads the result register.
// No new item is taken until the unit is back in idle.
// A walk starts only when the result register is free or being emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker_unit
    import ptw_pkg::*;
#(
    parameter int STORE_WORDS = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [ADDR_W-1:0] cfg_wr_data,
    ptw_cmd_if.sink                cmd,
    ptw_rsp_if.source              rsp
);

    ctl_t ctl;
    sts_t sts;

    // Controller.
    ptw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_mode  (cmd.mode),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Datapath.
    ptw_datapath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .word_phys_addr (cmd.word_phys_addr),
        .word_value     (cmd.word_value),
        .virt_addr      (cmd.virt_addr),
        .ctl            (ctl),
        .sts            (sts),
        .phys_addr      (rsp.phys_addr),
        .translated     (rsp.translated),
        .page_size      (rsp.page_size)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ptw_ram.sv -----
// ----------------------------------------------------------------------------
// ptw_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ptw_datapath.sv -----
// ----------------------------------------------------------------------------
// ptw_datapath
// Table store, root register, walk address formation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_datapath
    import ptw_pkg::*;
#(
    parameter int STORE_WORDS = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [ADDR_W-1:0]   cfg_wr_data,
    input  wire logic [ADDR_W-1:0]   word_phys_addr,
    input  wire logic [WORD_W-1:0]   word_value,
    input  wire logic [VA_W-1:0]     virt_addr,
    input  wire ctl_t                ctl,
    output sts_t                     sts,
    output logic      [ADDR_W-1:0]   phys_addr,
    output logic                     translated,
    output logic      [PSIZE_W-1:0]  page_size
);

    localparam int AW = $clog2(STORE_WORDS);

    logic [ADDR_W-1:0]     root_reg;
    logic [VA_W-1:0]       va_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic [AW-1:0]         clr_cnt_next;
    logic [ADDR_W-1:0]     pa_reg;
    logic                  ok_reg;
    logic [PSIZE_W-1:0]    size_reg;
    logic [WORD_W-1:0]     entry;
    logic [FRAME_W-1:0]    base;
    logic [IDX_W-1:0]      idx;
    logic [WORD_IDX_W-1:0] rd_word;
    logic [WORD_IDX_W-1:0] wr_word;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;

    // Root table register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            root_reg <= cfg_wr_data;
        end
    end

    // Virtual address of the walk in progress.
    always_ff @(posedge clk)
    begin
        if (ctl.load_va)
        begin
            va_reg <= virt_addr;
        end
    end

    // Clearing pass counter.
    assign clr_cnt_next = clr_cnt_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == AW'(STORE_WORDS - 1));

    // Write address check and store write port.
    assign wr_word    = word_phys_addr[ADDR_W-1:3];
    assign sts.wr_ok  = (wr_word < WORD_IDX_W'(STORE_WORDS));
    assign ram_we     = ctl.wr_en | ctl.clr_step;
    assign ram_waddr  = ctl.clr_step ? clr_cnt_reg : wr_word[AW-1:0];
    assign ram_wdata  = ctl.clr_step ? '0 : word_value;

    // Index of the entry in the table at the requested level.
    always_comb
    begin
        unique case (ctl.level)
            LVL_PML4: idx = va_reg[47:39];
            LVL_PDPT: idx = va_reg[38:30];
            LVL_PD:   idx = va_reg[29:21];
            LVL_PT:   idx = va_reg[20:12];
        endcase
    end

    // Next table comes from the root or from the entry just read.
    assign base         = ctl.sel_root ? root_reg[ADDR_W-1:12] : entry[ADDR_W-1:12];
    assign rd_word      = {base, idx};
    assign sts.addr_ok  = (rd_word < WORD_IDX_W'(STORE_WORDS));
    assign sts.present  = entry[BIT_PRESENT];
    assign sts.big_page = entry[BIT_LARGE];

    ptw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.rd_en),
        .raddr (rd_word[AW-1:0]),
        .rdata (entry)
    );

    // Result register, loaded when a walk ends.
    always_ff @(posedge clk)
    begin
        if (ctl.load_result)
        begin
            unique case (ctl.kind)
                RES_GIG:
                begin
                    pa_reg   <= {entry[ADDR_W-1:30], va_reg[29:0]};
                    ok_reg   <= 1'b1;
                    size_reg <= PS_1G;
                end
                RES_MEG:
                begin
                    pa_reg   <= {entry[ADDR_W-1:21], va_reg[20:0]};
                    ok_reg   <= 1'b1;
                    size_reg <= PS_2M;
                end
                RES_SMALL:
                begin
                    pa_reg   <= {entry[ADDR_W-1:12], va_reg[11:0]};
                    ok_reg   <= 1'b1;
                    size_reg <= PS_4K;
                end
                RES_FAULT:
                begin
                    pa_reg   <= '0;
                    ok_reg   <= 1'b0;
                    size_reg <= PS_4K;
                end
            endcase
        end
    end

    assign phys_addr  = pa_reg;
    assign translated = ok_reg;
    assign page_size  = size_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ptw_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptw_ctrl
// Controller: clearing pass, item intake, level sequencing, result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_ctrl
    import ptw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire logic cmd_mode,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    input  wire sts_t sts,
    output ctl_t      ctl
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_START = 4'b0100,
        S_WALK  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    lvl_t   level_reg;
    lvl_t   level_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // Next-state and command logic.
    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        ctl        = '0;
        ctl.kind   = RES_FAULT;
        cmd_ready  = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // An item is taken only when the result slot is free or being emptied.
                cmd_ready = !rsp_valid_reg || rsp_ready;
                if (cmd_valid && cmd_ready)
                begin
                    if (cmd_mode == MODE_WRITE)
                    begin
                        ctl.wr_en = sts.wr_ok;
                    end
                    else
                    begin
                        ctl.load_va = 1'b1;
                        state_next  = S_START;
                    end
                end
            end
            S_START:
            begin
                ctl.level    = LVL_PML4;
                ctl.sel_root = 1'b1;
                if (sts.addr_ok)
                begin
                    ctl.rd_en  = 1'b1;
                    level_next = LVL_PML4;
                    state_next = S_WALK;
                end
                else
                begin
                    ctl.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_WALK:
            begin
                // The entry of level_reg is on the store output.
                ctl.level = level_reg + lvl_t'(1);
                priority if (!sts.present)
                begin
                    ctl.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (level_reg == LVL_PDPT && sts.big_page)
                begin
                    ctl.load_result = 1'b1;
                    ctl.kind        = RES_GIG;
                    state_next      = S_IDLE;
                end
                else if (level_reg == LVL_PD && sts.big_page)
                begin
                    ctl.load_result = 1'b1;
                    ctl.kind        = RES_MEG;
                    state_next      = S_IDLE;
                end
                else if (level_reg == LVL_PT)
                begin
                    ctl.load_result = 1'b1;
                    ctl.kind        = RES_SMALL;
                    state_next      = S_IDLE;
                end
                else if (sts.addr_ok)
                begin
                    ctl.rd_en  = 1'b1;
                    level_next = level_reg + lvl_t'(1);
                end
                else
                begin
                    ctl.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag.
    assign rsp_valid_next = ctl.load_result || (rsp_valid_reg && !rsp_ready);
    assign rsp_valid      = rsp_valid_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            level_reg     <= LVL_PML4;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ptw_checker.sv -----
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks for the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_checker
    import ptw_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cmd_valid,
    input wire logic               cmd_ready,
    input wire logic               cmd_mode,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic [ADDR_W-1:0]  phys_addr,
    input wire logic               translated,
    input wire logic [PSIZE_W-1:0] page_size
);

    // A stalled result keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result valid dropped while stalled");

    // A fault reports a zero address and the smallest page size.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !translated |-> phys_addr == '0 && page_size == PS_4K)
    else $error("fault result carries a nonzero address or size");

    // Page size code is never the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> page_size == PS_4K || page_size == PS_2M || page_size == PS_1G)
    else $error("unused page size code");

    // A walk blocks new items for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_mode == MODE_TRANSLATE |=> !cmd_ready)
    else $error("item taken while a walk is starting");

    // No result appears in the cycle right after a translate is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_mode == MODE_TRANSLATE && rsp_ready
        |=> !rsp_valid)
    else $error("result produced without a table read");

endmodule

bind four_level_page_table_walker_unit ptw_checker u_ptw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_mode   (cmd.mode),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .phys_addr  (rsp.phys_addr),
    .translated (rsp.translated),
    .page_size  (rsp.page_size)
);

`default_nettype wire
